[design/sm_pkg.sv]
// Shared types and constants for the int8 softmax lookup block.
// No dependencies; sm_ctrl, sm_dp and int8_softmax_lut import this package.
`default_nettype none
package sm_pkg;

    localparam int EXP_W   = 32;   // table entry width, unsigned Q16.16
    localparam int SUM_W   = 38;   // row sum width
    localparam int DEN_W   = 64;   // denominator width kept for division
    localparam int NUM_W   = 49;   // table entry shifted left by 17
    localparam int NUM_SH  = 17;
    localparam int TIDX_W  = 8;
    localparam int CNT_W   = 6;    // divider step counter
    localparam int CH_W    = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REG_CHANNELS   = 2'd0;
    localparam logic [1:0] REG_SCALE      = 2'd1;
    localparam logic [1:0] REG_ZERO_POINT = 2'd2;

    localparam logic [CH_W-1:0]   CHANNELS_RST = 7'd1;
    localparam logic [EXP_W-1:0]  SCALE_RST    = 32'd65536;
    localparam logic signed [7:0] SAT_MAX      = 8'sd127;
    localparam logic signed [7:0] SAT_MIN      = -8'sd128;

    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef struct packed {
        logic load_table;
        logic store_elem;
        logic accum;
        logic mul_lo;
        logic mul_hi;
        logic den_load;
        logic div_init;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic row_done;
        logic div_done;
        logic out_free;
        logic row_end;
    } stat_t;

endpackage
`default_nettype wire

[design/sm_if.sv]
// Handshake channel interfaces for input items and result items.
// Depends on nothing.
`default_nettype none
interface sm_item_if;
    logic              valid;
    logic              ready;
    logic              op;
    logic [7:0]        table_index;
    logic [31:0]       table_value;
    logic signed [7:0] data_value;

    modport source (output valid, op, table_index, table_value, data_value, input ready);
    modport sink   (input valid, op, table_index, table_value, data_value, output ready);
endinterface

interface sm_result_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] out_value;
    logic              out_last;

    modport source (output valid, out_value, out_last, input ready);
    modport sink   (input valid, out_value, out_last, output ready);
endinterface
`default_nettype wire

[design/sm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module sm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/sm_ctrl.sv]
// Sequencer for the softmax block: accumulation, denominator and per-element division.
// Depends on sm_pkg.
`default_nettype none
module sm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          item_op,
    output logic               item_ready,
    input  wire sm_pkg::stat_t stat,
    output sm_pkg::cmd_t       cmd
);
    import sm_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_ACCUM    = 10'b0000000010,
        ST_MUL_LO   = 10'b0000000100,
        ST_MUL_HI   = 10'b0000001000,
        ST_DEN      = 10'b0000010000,
        ST_RD_ROW   = 10'b0000100000,
        ST_RD_EXP   = 10'b0001000000,
        ST_DIV_INIT = 10'b0010000000,
        ST_DIV      = 10'b0100000000,
        ST_EMIT     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_table = accept && (item_op == OP_TABLE);
                cmd.store_elem = accept && (item_op == OP_DATA);
                if (accept && (item_op == OP_DATA))
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.row_done ? ST_MUL_LO : ST_IDLE;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.den_load = 1'b1;
                state_next   = ST_RD_ROW;
            end
            ST_RD_ROW:
            begin
                state_next = ST_RD_EXP;
            end
            ST_RD_EXP:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.row_end ? ST_IDLE : ST_RD_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

[design/sm_dp.sv]
// Datapath: table and row memories, row sum, denominator, restoring divider, output register.
// Depends on sm_pkg and sm_ram.
`default_nettype none
module sm_dp #(
    parameter int MAX_CHANNELS = 64,
    parameter int TABLE_DEPTH  = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sm_pkg::cmd_t               cmd,
    output sm_pkg::stat_t                   stat,
    input  wire logic [sm_pkg::TIDX_W-1:0]  table_index,
    input  wire logic [sm_pkg::EXP_W-1:0]   table_value,
    input  wire logic signed [7:0]          data_value,
    input  wire logic [sm_pkg::CH_W-1:0]    channels,
    input  wire logic [sm_pkg::EXP_W-1:0]   scale_q16,
    input  wire logic signed [7:0]          zero_point,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [7:0]               out_value,
    output logic                            out_last
);
    import sm_pkg::*;

    localparam int RAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam logic [CH_W-1:0] MAX_CH = CH_W'(MAX_CHANNELS);

    logic [CH_W-1:0]  pos_reg, k_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [63:0]      lo_prod_reg;
    logic [37:0]      hi_prod_reg;
    logic [DEN_W-1:0] den_reg;
    logic             den_zero_reg, den_huge_reg;
    logic [NUM_W-1:0] num_reg, quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg, out_last_reg;
    logic signed [7:0] out_value_reg;

    logic [CH_W-1:0]  row_len, pos_inc, wpos;
    logic [RAW-1:0]   row_waddr, row_raddr;
    logic [7:0]       row_rdata;
    logic [EXP_W-1:0] exp_rdata;
    logic [TAW-1:0]   exp_raddr;
    logic [69:0]      den_full;
    logic [DEN_W:0]   rem_sh, rem_sub;
    logic [NUM_W:0]   q_round;
    logic [NUM_W-1:0] q_half;
    logic signed [9:0] v_sum;
    logic signed [7:0] result;

    always_comb
    begin
        if (channels == '0)
        begin
            row_len = CH_W'(1);
        end
        else if (channels > MAX_CH)
        begin
            row_len = MAX_CH;
        end
        else
        begin
            row_len = channels;
        end
    end

    // Store position clamps at the last slot.
    assign wpos      = (pos_reg >= MAX_CH) ? (MAX_CH - CH_W'(1)) : pos_reg;
    assign row_waddr = wpos[RAW-1:0];
    assign row_raddr = k_reg[RAW-1:0];
    assign pos_inc   = wpos + CH_W'(1);
    assign exp_raddr = cmd.store_elem ? TAW'(data_value) : TAW'(row_rdata);

    sm_ram #(.WIDTH(EXP_W), .DEPTH(TABLE_DEPTH)) u_exp_ram (
        .clk   (clk),
        .we    (cmd.load_table),
        .waddr (TAW'(table_index)),
        .wdata (table_value),
        .raddr (exp_raddr),
        .rdata (exp_rdata)
    );

    sm_ram #(.WIDTH(8), .DEPTH(MAX_CHANNELS)) u_row_ram (
        .clk   (clk),
        .we    (cmd.store_elem),
        .waddr (row_waddr),
        .wdata (data_value),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    assign den_full = {hi_prod_reg, 32'd0} + {6'd0, lo_prod_reg};

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign q_round = {1'b0, quot_reg} + (NUM_W+1)'(1);
    assign q_half  = q_round[NUM_W:1];
    assign v_sum   = $signed({2'b00, q_half[7:0]}) + 10'(zero_point);

    always_comb
    begin
        if (den_zero_reg)
        begin
            result = SAT_MAX;
        end
        else if (den_huge_reg)
        begin
            result = zero_point;
        end
        else if (q_half > NUM_W'(255))
        begin
            result = SAT_MAX;
        end
        else if (v_sum > 10'sd127)
        begin
            result = SAT_MAX;
        end
        else if (v_sum < -10'sd128)
        begin
            result = SAT_MIN;
        end
        else
        begin
            result = v_sum[7:0];
        end
    end

    always_comb
    begin
        stat.row_done = (pos_inc >= row_len);
        stat.div_done = (cnt_reg == CNT_W'(NUM_W - 1));
        stat.out_free = !out_valid_reg || out_ready;
        stat.row_end  = ((k_reg + CH_W'(1)) == pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accum)
            begin
                pos_reg <= pos_inc;
                sum_reg <= sum_reg + SUM_W'(exp_rdata);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (stat.row_end)
                begin
                    k_reg   <= '0;
                    pos_reg <= '0;
                    sum_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg + CH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            lo_prod_reg <= 64'(sum_reg[31:0]) * 64'(scale_q16);
        end
        if (cmd.mul_hi)
        begin
            hi_prod_reg <= 38'(sum_reg[37:32]) * 38'(scale_q16);
        end
        if (cmd.den_load)
        begin
            den_reg      <= den_full[DEN_W-1:0];
            den_huge_reg <= (den_full[69:64] != '0);
            den_zero_reg <= (den_full == '0);
        end
        if (cmd.div_init)
        begin
            num_reg  <= {exp_rdata, NUM_SH'(0)};
            rem_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (!rem_sub[DEN_W])
            begin
                rem_reg  <= rem_sub[DEN_W-1:0];
                quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[DEN_W-1:0];
                quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            out_value_reg <= result;
            out_last_reg  <= stat.row_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
endmodule
`default_nettype wire

[design/int8_softmax_lut.sv]
// Top level of the int8 softmax lookup block: APB register file, controller, datapath.
// Depends on sm_pkg, sm_if, sm_ram, sm_ctrl and sm_dp.
//
// Usage:
//   Load the 256-entry exponent table first: items with op=0 write table_value at
//   table_index and produce no result. Items with op=1 carry one int8 element each;
//   the element is stored and its table entry is added to the row sum. When the
//   configured channel count is reached, one result per element is sent on the
//   result channel in arrival order, out_last marking the final one.
//   An element item is accepted, then its entry is accumulated from the table RAM.
//   At row end, the 64-bit denominator is formed (a 32x32 and a 6x32 multiply of the
//   row sum by scale_q16, then an add); each result then takes a row RAM read, a
//   table RAM read, a divider load, 49 steps of the one-bit-per-cycle restoring
//   divider, and the load into the output register. The divider sets the rate.
//   Inputs are refused while a row is being emitted. If the receiver stalls, the
//   finished result holds in the output register and the sequencer waits.
//   Reset clears the row count and sum and sets channels=1, scale=1.0, zero
//   point=0; table and row memories hold garbage until written.
//   Registers: 0 channels, 1 scale_q16, 2 zero_point, at byte address 4*index.
`default_nettype none
module int8_softmax_lut #(
    parameter int MAX_CHANNELS = 64,
    parameter int TABLE_DEPTH  = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    sm_item_if.sink                         item,
    sm_result_if.source                     result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sm_pkg::DATA_W-1:0]  pwdata,
    output logic      [sm_pkg::DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sm_pkg::*;

    logic [CH_W-1:0]   channels_reg;
    logic [EXP_W-1:0]  scale_reg;
    logic signed [7:0] zero_point_reg;
    logic [1:0]        reg_sel;
    logic              wr_en;
    cmd_t              cmd;
    stat_t             stat;
    logic              item_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register file: writes land on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg   <= CHANNELS_RST;
            scale_reg      <= SCALE_RST;
            zero_point_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_CHANNELS:   channels_reg   <= pwdata[CH_W-1:0];
                REG_SCALE:      scale_reg      <= pwdata;
                REG_ZERO_POINT: zero_point_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CHANNELS:   prdata = DATA_W'(channels_reg);
            REG_SCALE:      prdata = scale_reg;
            REG_ZERO_POINT: prdata = DATA_W'(zero_point_reg);
            default:        prdata = '0;
        endcase
    end

    sm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.op),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    assign item.ready = item_ready;

    sm_dp #(.MAX_CHANNELS(MAX_CHANNELS), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .table_index (item.table_index),
        .table_value (item.table_value),
        .data_value  (item.data_value),
        .channels    (channels_reg),
        .scale_q16   (scale_reg),
        .zero_point  (zero_point_reg),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_value   (result.out_value),
        .out_last    (result.out_last)
    );
endmodule
`default_nettype wire
